/* hdl/ssed_pkg.sv */
package ssed_pkg;

  // configuration register widths
  localparam int CFG_WIDTH_W  = 11;
  localparam int CFG_MARGIN_W = 15;
  localparam int CFG_BORDER_W = 4;
  localparam int CFG_DATA_W   = 15;
  localparam int CFG_IDX_W    = 2;

  // result field width
  localparam int KEY_W = 10;

  // smallest frame size the window logic handles
  localparam int DIM_MIN = 9;

  // reset values of the configuration registers
  localparam logic [CFG_WIDTH_W-1:0]  RST_IMAGE_WIDTH  = 11'd640;
  localparam logic [CFG_WIDTH_W-1:0]  RST_IMAGE_HEIGHT = 11'd480;
  localparam logic [CFG_MARGIN_W-1:0] RST_CONTRAST     = 15'd205;
  localparam logic [CFG_BORDER_W-1:0] RST_BORDER       = 4'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH     = 2'd0,
    CFG_IMAGE_HEIGHT    = 2'd1,
    CFG_CONTRAST_MARGIN = 2'd2,
    CFG_BORDER_MARGIN   = 2'd3
  } cfg_idx_t;

endpackage

/* hdl/scale_space_extremum_detector_core.sv */
// 3x3x3 extremum detector over three difference-of-Gaussian levels. One pixel
// position (lower, centre and upper sample) is taken every clock; the block
// only holds the input when a result waits on a stalled output and the next
// window is also a hit. A hit passes stage 1, the window and the result
// register after the item that completes its window (the pixel one row down
// and one column right of the reported position). The two previous rows live
// in one memory of MAX_WIDTH words of six samples, read at the accepted column
// and written back from stage 1, so throughput is set by that single read and
// write port: one item per clock unless held. Width and height are clamped to
// 9..MAX_WIDTH and 9..MAX_HEIGHT, a border margin of zero acts as one, and
// counters restart on frame_start or wrap at the end of a frame. Configuration
// must be written by the user only while no item is in flight; not enforced.
module scale_space_extremum_detector_core #(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_HEIGHT  = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  ssed_pkg::cfg_idx_t                  cfg_index,
  input  logic [ssed_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample_lower,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample_center,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample_upper,
  input  logic                                in_frame_start,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ssed_pkg::KEY_W-1:0]          out_key_row,
  output logic [ssed_pkg::KEY_W-1:0]          out_key_col
);
  import ssed_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = (CW + 1 > CFG_WIDTH_W) ? CW + 1 : CFG_WIDTH_W;
  localparam int HW = (RW + 1 > CFG_WIDTH_W) ? RW + 1 : CFG_WIDTH_W;
  localparam int EW = ((SB > CFG_MARGIN_W) ? SB : CFG_MARGIN_W) + 2;
  localparam int LW = 3 * SB;

  // configuration
  logic [CFG_WIDTH_W-1:0]  width_r, height_r;
  logic [CFG_MARGIN_W-1:0] margin_r;
  logic [CFG_BORDER_W-1:0] border_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_IMAGE_WIDTH;
      height_r <= RST_IMAGE_HEIGHT;
      margin_r <= RST_CONTRAST;
      border_r <= RST_BORDER;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:     width_r  <= cfg_data[CFG_WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT:    height_r <= cfg_data[CFG_WIDTH_W-1:0];
        CFG_CONTRAST_MARGIN: margin_r <= cfg_data[CFG_MARGIN_W-1:0];
        CFG_BORDER_MARGIN:   border_r <= cfg_data[CFG_BORDER_W-1:0];
        default: ;
      endcase
    end
  end

  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [CFG_BORDER_W-1:0] bm_eff;

  always_comb begin
    if (WW'(width_r) < WW'(DIM_MIN))        w_eff = WW'(DIM_MIN);
    else if (WW'(width_r) > WW'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else                                    w_eff = WW'(width_r);
    if (HW'(height_r) < HW'(DIM_MIN))         h_eff = HW'(DIM_MIN);
    else if (HW'(height_r) > HW'(MAX_HEIGHT)) h_eff = HW'(MAX_HEIGHT);
    else                                      h_eff = HW'(height_r);
    bm_eff = (border_r == '0) ? CFG_BORDER_W'(1) : border_r;
  end

  // pipeline control
  logic adv, in_accept, hit;
  assign adv       = !(out_valid && out_stall && hit);
  assign in_stall  = !adv;
  assign in_accept = in_valid && adv;

  // position counters
  logic [CW-1:0] col_r, col_nxt, col_cur;
  logic [RW-1:0] row_r, row_nxt, row_cur;
  logic          pos_ok;

  always_comb begin
    logic [CW-1:0] c0;
    logic [RW-1:0] r0;
    logic [WW-1:0] c_inc;
    logic [HW-1:0] r_inc;
    c0 = in_frame_start ? '0 : col_r;
    r0 = in_frame_start ? '0 : row_r;
    col_cur = (WW'(c0) >= w_eff) ? '0 : c0;
    row_cur = (HW'(r0) >= h_eff) ? '0 : r0;
    c_inc = WW'(col_cur) + WW'(1);
    r_inc = HW'(row_cur) + HW'(1);
    if (c_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = (r_inc >= h_eff) ? '0 : r_inc[RW-1:0];
    end else begin
      col_nxt = c_inc[CW-1:0];
      row_nxt = row_cur;
    end
    // centre sits one row up and one column left of the newest pixel
    pos_ok = (WW'(col_cur) >= WW'(bm_eff) + WW'(1)) &&
             (WW'(col_cur) + WW'(bm_eff) <= w_eff) &&
             (HW'(row_cur) >= HW'(bm_eff) + HW'(1)) &&
             (HW'(row_cur) + HW'(bm_eff) <= h_eff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // line store: upper half is the older row, lower half the newer row
  logic [2*LW-1:0] line_mem [MAX_WIDTH];
  logic [2*LW-1:0] rd_r, fwd_data_r, line_word, wr_data;
  logic            fwd_hit_r;

  // stage 1
  logic          s1_valid_r;
  logic [CW-1:0] s1_addr_r, s1_kc_r;
  logic [RW-1:0] s1_kr_r;
  logic          s1_ok_r;
  logic [LW-1:0] s1_cur_r;

  assign line_word = fwd_hit_r ? fwd_data_r : rd_r;
  assign wr_data   = {line_word[LW-1:0], s1_cur_r};

  always_ff @(posedge clk) begin
    if (in_accept) begin
      rd_r       <= line_mem[col_cur];
      fwd_data_r <= wr_data;
      // same column written back this edge, e.g. frame_start twice in a row
      fwd_hit_r  <= s1_valid_r && (s1_addr_r == col_cur);
    end
    if (s1_valid_r && adv) begin
      line_mem[s1_addr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_addr_r <= col_cur;
      s1_kc_r   <= col_cur - CW'(1);
      s1_kr_r   <= row_cur - RW'(1);
      s1_ok_r   <= pos_ok;
      s1_cur_r  <= {in_sample_upper, in_sample_center, in_sample_lower};
    end
  end

  // stage 2: the 3x3x3 window, indexed [column][row][level]
  logic signed [SB-1:0] win_r [3][3][3];
  logic                 s2_valid_r;
  logic                 s2_ok_r;
  logic [CW-1:0]        s2_kc_r;
  logic [RW-1:0]        s2_kr_r;

  always_ff @(posedge clk) begin
    if (s1_valid_r && adv) begin
      for (int y = 0; y < 3; y++) begin
        for (int z = 0; z < 3; z++) begin
          win_r[0][y][z] <= win_r[1][y][z];
          win_r[1][y][z] <= win_r[2][y][z];
        end
      end
      for (int z = 0; z < 3; z++) begin
        win_r[2][0][z] <= line_word[LW + z*SB +: SB];
        win_r[2][1][z] <= line_word[z*SB +: SB];
        win_r[2][2][z] <= s1_cur_r[z*SB +: SB];
      end
      s2_ok_r <= s1_ok_r;
      s2_kc_r <= s1_kc_r;
      s2_kr_r <= s1_kr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  // 26 neighbour compares against centre -/+ margin
  always_comb begin
    logic signed [EW-1:0] ctr, mgn, lo, hi, v;
    logic is_max, is_min;
    ctr = EW'(win_r[1][1][1]);
    mgn = EW'($signed({1'b0, margin_r}));
    lo  = ctr - mgn;
    hi  = ctr + mgn;
    is_max = 1'b1;
    is_min = 1'b1;
    for (int x = 0; x < 3; x++) begin
      for (int y = 0; y < 3; y++) begin
        for (int z = 0; z < 3; z++) begin
          v = EW'(win_r[x][y][z]);
          if (!(x == 1 && y == 1 && z == 1)) begin
            if (v > lo) is_max = 1'b0;
            if (v < hi) is_min = 1'b0;
          end
        end
      end
    end
    hit = s2_valid_r && s2_ok_r && (is_max || is_min);
  end

  // result register
  logic             out_valid_r;
  logic [KEY_W-1:0] key_row_r, key_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (hit && adv) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hit && adv) begin
      key_row_r <= KEY_W'(s2_kr_r);
      key_col_r <= KEY_W'(s2_kc_r);
    end
  end

  assign out_valid   = out_valid_r;
  assign out_key_row = key_row_r;
  assign out_key_col = key_col_r;

endmodule

/* dv/ssed_keypoint_checker.sv */
`timescale 1ns / 1ps

module ssed_keypoint_checker #(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_HEIGHT  = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  ssed_pkg::cfg_idx_t              cfg_index,
  input  logic [ssed_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic signed [SAMPLE_BITS-1:0]   in_sample_lower,
  input  logic signed [SAMPLE_BITS-1:0]   in_sample_center,
  input  logic signed [SAMPLE_BITS-1:0]   in_sample_upper,
  input  logic                            in_frame_start,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [ssed_pkg::KEY_W-1:0]      out_key_row,
  input  logic [ssed_pkg::KEY_W-1:0]      out_key_col,
  output int                              error_count,
  output int                              keys_pending,
  output int                              keys_checked
);
  import ssed_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] lower;
    logic signed [SAMPLE_BITS-1:0] center;
    logic signed [SAMPLE_BITS-1:0] upper;
  } level_px_t;

  typedef struct packed {
    logic [KEY_W-1:0] row;
    logic [KEY_W-1:0] col;
  } keypoint_t;

  logic [CFG_WIDTH_W-1:0]  width_reg;
  logic [CFG_WIDTH_W-1:0]  height_reg;
  logic [CFG_MARGIN_W-1:0] contrast_reg;
  logic [CFG_BORDER_W-1:0] border_reg;

  level_px_t line_mem [2][MAX_WIDTH];
  // [column][row], column 2 and row 2 are the newest
  level_px_t win [3][3];
  int        col_cnt;
  int        row_cnt;
  keypoint_t keypoint_q[$];
  int        errs;
  int        checked;

  function automatic bit window_is_extremum();
    int ctr;
    int marg;
    int v;
    bit is_max;
    bit is_min;
    ctr    = int'(win[1][1].center);
    marg   = int'(contrast_reg);
    is_max = 1'b1;
    is_min = 1'b1;
    for (int x = 0; x < 3; x++) begin
      for (int y = 0; y < 3; y++) begin
        for (int z = 0; z < 3; z++) begin
          if (x == 1 && y == 1 && z == 1) continue;
          case (z)
            0: v = int'(win[x][y].lower);
            1: v = int'(win[x][y].center);
            default: v = int'(win[x][y].upper);
          endcase
          if (v > ctr - marg) is_max = 1'b0;
          if (v < ctr + marg) is_min = 1'b0;
        end
      end
    end
    return is_max || is_min;
  endfunction

  task automatic predict_keypoint(input level_px_t px, input logic fs);
    int w;
    int h;
    int bm;
    int r;
    int c;
    keypoint_t k;
    w = int'(width_reg);
    if (w < DIM_MIN) w = DIM_MIN;
    else if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = int'(height_reg);
    if (h < DIM_MIN) h = DIM_MIN;
    else if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    bm = int'(border_reg);
    if (bm < 1) bm = 1;

    if (fs) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    if (col_cnt >= w) col_cnt = 0;
    if (row_cnt >= h) row_cnt = 0;
    r = row_cnt;
    c = col_cnt;

    for (int y = 0; y < 3; y++) begin
      win[0][y] = win[1][y];
      win[1][y] = win[2][y];
    end
    win[2][0] = line_mem[0][c];
    win[2][1] = line_mem[1][c];
    win[2][2] = px;
    line_mem[0][c] = line_mem[1][c];
    line_mem[1][c] = px;

    // tested centre sits one row up and one column left of the newest item
    if (r >= 1 && c >= 1) begin
      if (r - 1 >= bm && c - 1 >= bm && r - 1 + bm < h && c - 1 + bm < w &&
          window_is_extremum()) begin
        k.row = KEY_W'(r - 1);
        k.col = KEY_W'(c - 1);
        keypoint_q.push_back(k);
      end
    end

    col_cnt = c + 1;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt = r + 1;
      if (row_cnt >= h) row_cnt = 0;
    end
  endtask

  always @(posedge clk) begin
    keypoint_t exp_k;
    if (!rst_n) begin
      width_reg    = RST_IMAGE_WIDTH;
      height_reg   = RST_IMAGE_HEIGHT;
      contrast_reg = RST_CONTRAST;
      border_reg   = RST_BORDER;
      foreach (win[x, y]) win[x][y] = '0;
      foreach (line_mem[i, j]) line_mem[i][j] = '0;
      col_cnt = 0;
      row_cnt = 0;
      keypoint_q.delete();
      errs    = 0;
      checked = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH:     width_reg    = cfg_data[CFG_WIDTH_W-1:0];
          CFG_IMAGE_HEIGHT:    height_reg   = cfg_data[CFG_WIDTH_W-1:0];
          CFG_CONTRAST_MARGIN: contrast_reg = cfg_data[CFG_MARGIN_W-1:0];
          CFG_BORDER_MARGIN:   border_reg   = cfg_data[CFG_BORDER_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (keypoint_q.size() == 0) begin
          errs++;
          $display("%0t: unexpected keypoint, expected none, actual row %0d col %0d",
                   $time, out_key_row, out_key_col);
        end else begin
          exp_k = keypoint_q.pop_front();
          checked++;
          if (out_key_row !== exp_k.row || out_key_col !== exp_k.col) begin
            errs++;
            $display("%0t: keypoint mismatch, expected row %0d col %0d, actual row %0d col %0d",
                     $time, exp_k.row, exp_k.col, out_key_row, out_key_col);
          end
        end
      end
      if (in_valid && !in_stall)
        predict_keypoint({in_sample_lower, in_sample_center, in_sample_upper}, in_frame_start);
    end
    error_count  <= errs;
    keys_pending <= keypoint_q.size();
    keys_checked <= checked;
  end

endmodule

/* dv/scale_space_extremum_detector_core_tb.sv */
`timescale 1ns / 1ps

module scale_space_extremum_detector_core_tb;
  import ssed_pkg::*;

  localparam int MAX_DIM       = 1024;
  localparam int SAMPLE_BITS   = 16;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 8;

  typedef enum int {
    PAT_SPARSE,
    PAT_FLAT,
    PAT_NOISE
  } pixel_pattern_t;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  cfg_idx_t                      cfg_index;
  logic [CFG_DATA_W-1:0]         cfg_data;
  logic                          in_valid;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] in_sample_lower;
  logic signed [SAMPLE_BITS-1:0] in_sample_center;
  logic signed [SAMPLE_BITS-1:0] in_sample_upper;
  logic                          in_frame_start;
  logic                          out_valid;
  logic                          out_stall;
  logic [KEY_W-1:0]              out_key_row;
  logic [KEY_W-1:0]              out_key_col;
  int                            error_count;
  int                            keys_pending;
  int                            keys_checked;

  bit src_idle;
  bit sink_idle;
  bit hold_pending;
  int pixels_sent;
  int configs_used;
  int cycles;

  scale_space_extremum_detector_core #(
    .MAX_WIDTH  (MAX_DIM),
    .MAX_HEIGHT (MAX_DIM),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) i_dut (.*);

  ssed_keypoint_checker #(
    .MAX_WIDTH  (MAX_DIM),
    .MAX_HEIGHT (MAX_DIM),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) i_keypoint_checker (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("scale_space_extremum_detector_core_tb failed");
    $finish;
  end

  function automatic int clamp_dim(input logic [CFG_WIDTH_W-1:0] v);
    if (v < DIM_MIN) return DIM_MIN;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  // wait until every expected keypoint is out, then let the pipeline drain
  task automatic settle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (keys_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] w_raw, h_raw, m_raw, b_raw);
    settle();
    write_cfg(CFG_IMAGE_WIDTH, w_raw);
    write_cfg(CFG_IMAGE_HEIGHT, h_raw);
    write_cfg(CFG_CONTRAST_MARGIN, m_raw);
    write_cfg(CFG_BORDER_MARGIN, b_raw);
    cfg_we <= 1'b0;
    configs_used++;
  endtask

  task automatic send_pixel(input logic signed [SAMPLE_BITS-1:0] s_lo, s_ce, s_up,
                            input logic fs);
    int gap;
    gap = src_idle ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_sample_lower  <= s_lo;
    in_sample_center <= s_ce;
    in_sample_upper  <= s_up;
    in_frame_start   <= fs;
    do @(posedge clk); while (in_stall);
    pixels_sent++;
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] w_raw, h_raw, m_raw, b_raw,
                           input pixel_pattern_t pat, input int n, input bit with_hold);
    int frame_len;
    int pos;
    int k_flat;
    int lo;
    int ce;
    int up;
    logic fs;
    configure(w_raw, h_raw, m_raw, b_raw);
    src_idle     = with_hold ? 1'b0 : ($urandom_range(0, 3) != 0);
    sink_idle    = $urandom_range(0, 3) != 0;
    hold_pending = with_hold;
    frame_len    = clamp_dim(w_raw[CFG_WIDTH_W-1:0]) * clamp_dim(h_raw[CFG_WIDTH_W-1:0]);
    k_flat       = $urandom;
    pos          = 0;
    for (int i = 0; i < n; i++) begin
      if (pos == frame_len) pos = 0;
      // every phase opens a frame; later frames may wrap without a frame start
      fs = (i == 0) || (pos == 0 && $urandom_range(0, 1) == 1);
      if (pos != 0 && $urandom_range(0, 149) == 0) begin
        fs  = 1'b1;
        pos = 0;
      end
      case (pat)
        PAT_SPARSE: begin
          lo = int'($urandom_range(0, 200)) - 100;
          ce = int'($urandom_range(0, 200)) - 100;
          up = int'($urandom_range(0, 200)) - 100;
          if ($urandom_range(0, 11) == 0)
            ce = $urandom_range(0, 1) ? int'($urandom_range(20000, 32767))
                                      : -int'($urandom_range(20000, 32768));
          if ($urandom_range(0, 39) == 0) lo = $urandom_range(0, 1) ? 32767 : -32768;
          if ($urandom_range(0, 39) == 0) up = $urandom_range(0, 1) ? 32767 : -32768;
        end
        PAT_FLAT: begin
          lo = k_flat;
          ce = k_flat;
          up = k_flat;
          if ($urandom_range(0, 39) == 0) ce = k_flat + ($urandom_range(0, 1) ? 1 : -1);
        end
        default: begin
          lo = $urandom;
          ce = $urandom;
          up = $urandom;
        end
      endcase
      send_pixel(SAMPLE_BITS'(lo), SAMPLE_BITS'(ce), SAMPLE_BITS'(up), fs);
      pos++;
    end
  endtask

  // output side: random stall per item, plus one long hold when asked
  initial begin
    int gap;
    out_stall <= 1'b1;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = sink_idle ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int r;
    int c;
    int lo;
    int ce;
    int up;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_IMAGE_WIDTH;
    cfg_data         <= '0;
    in_valid         <= 1'b0;
    in_sample_lower  <= '0;
    in_sample_center <= '0;
    in_sample_upper  <= '0;
    in_frame_start   <= 1'b0;
    src_idle         = 1'b1;
    sink_idle        = 1'b1;
    hold_pending     = 1'b0;
    pixels_sent      = 0;
    configs_used     = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // full-scale maximum and minimum against a zero background, widest margin
    configure(15'd9, 15'd9, 15'd32767, 15'd1);
    for (int i = 0; i < 24; i++) begin
      r  = i / 9;
      c  = i % 9;
      lo = 0;
      ce = 0;
      up = 0;
      if (r == 1 && c == 1) begin
        ce = 32767;
        lo = -32768;
        up = -32768;
      end
      if (r == 1 && c == 4) ce = -32768;
      send_pixel(SAMPLE_BITS'(lo), SAMPLE_BITS'(ce), SAMPLE_BITS'(up), i == 0);
    end

    // flat frames with zero margin and rare one-step centre changes: most interior positions are hits
    run_phase(15'd9, 15'd9, 15'd0, 15'd1, PAT_FLAT, 100, 1'b0);
    run_phase(15'd12, 15'd10, 15'd205, 15'd2, PAT_SPARSE, 120, 1'b0);
    // sizes below the minimum, border of zero, junk in the unused data bits
    run_phase(15'h7803, 15'h7800, CFG_DATA_W'($urandom_range(0, 300)), 15'h7FF0,
              PAT_SPARSE, 80, 1'b0);
    // back-to-back hits while the output holds off
    run_phase(15'd9, 15'd9, 15'd0, 15'd1, PAT_FLAT, 160, 1'b1);
    run_phase(15'd17, 15'd17, CFG_DATA_W'($urandom_range(0, 400)), 15'd8,
              PAT_SPARSE, 200, 1'b0);
    run_phase(15'd10, 15'd9, 15'd32767, 15'd15, PAT_NOISE, 60, 1'b0);
    // width beyond the line store clamps to the maximum
    run_phase(15'h7FFF, 15'd9, 15'd100, 15'd1, PAT_SPARSE, 60, 1'b0);
    run_phase(15'd9, 15'd1500, 15'd50, 15'd4, PAT_SPARSE, 100, 1'b0);
    repeat (4)
      run_phase(CFG_DATA_W'(9 + $urandom_range(0, 15)), CFG_DATA_W'(9 + $urandom_range(0, 11)),
                CFG_DATA_W'($urandom_range(0, 400)), CFG_DATA_W'($urandom_range(0, 8)),
                pixel_pattern_t'($urandom_range(0, 2)), 40, 1'b0);
    settle();

    $display("covered %0d pixel items over %0d register settings, %0d keypoints compared",
             pixels_sent, configs_used, keys_checked);
    $display("frames: flat, sparse peaks and random noise, clamped sizes, %0d-cycle output hold",
             HOLD_CYCLES);
    if (error_count == 0 && keys_pending == 0) begin
      $display("scale_space_extremum_detector_core_tb passed");
    end else begin
      $display("scale_space_extremum_detector_core_tb failed");
    end
    $finish;
  end

endmodule
